[sv/lfms_pkg.sv]
`default_nettype none
package lfms_pkg;

  localparam int SensW  = 4;
  localparam int DirW   = 4;
  localparam int DutyW  = 6;
  localparam int TrimW  = 4;
  localparam int CfgW   = 10;
  localparam int CfgIdxW = 3;

  // Sensor patterns, bit3 outer left down to bit0 outer right.
  localparam logic [SensW-1:0] SensNone      = 4'b0000;
  localparam logic [SensW-1:0] SensAll       = 4'b1111;
  localparam logic [SensW-1:0] SensCentre    = 4'b0110;
  localparam logic [SensW-1:0] SensInnerR    = 4'b0010;
  localparam logic [SensW-1:0] SensInnerL    = 4'b0100;
  localparam logic [SensW-1:0] SensCornerA   = 4'b1110;
  localparam logic [SensW-1:0] SensCornerB   = 4'b1100;
  localparam logic [SensW-1:0] SensOuterL    = 4'b1000;
  localparam logic [SensW-1:0] SensOuterR    = 4'b0001;

  // H-bridge direction codes.
  localparam logic [DirW-1:0] DirStop    = 4'd0;
  localparam logic [DirW-1:0] DirFwd     = 4'd6;
  localparam logic [DirW-1:0] DirPivot   = 4'd4;
  localparam logic [DirW-1:0] DirOneWhl  = 4'd2;

  // Duty constants.
  localparam logic [DutyW-1:0] DutyCruise = 6'd20;
  localparam logic [DutyW-1:0] DutySlow   = 6'd15;
  localparam logic [DutyW-1:0] DutyFast   = 6'd24;
  localparam logic [DutyW-1:0] DutyCrawl  = 6'd10;
  localparam logic [DutyW-1:0] DutyArcHi  = 6'd28;
  localparam logic [DutyW-1:0] DutyArcMax = 6'd30;

  // Configuration reset values.
  localparam logic [CfgW-1:0] CheckWaitRst  = 10'd4;
  localparam logic [CfgW-1:0] SettleWaitRst = 10'd50;
  localparam logic [CfgW-1:0] StopWaitRst   = 10'd200;
  localparam logic [CfgW-1:0] ExitWaitRst   = 10'd600;
  localparam logic [CfgW-1:0] FinalWaitRst  = 10'd300;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RIGHT_TRIM  = 3'd0,
    CFG_CHECK_WAIT  = 3'd1,
    CFG_SETTLE_WAIT = 3'd2,
    CFG_STOP_WAIT   = 3'd3,
    CFG_EXIT_WAIT   = 3'd4,
    CFG_FINAL_WAIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_PASS    = 4'd0,
    PH_RCHECK  = 4'd1,
    PH_LTURN   = 4'd2,
    PH_LCHECK  = 4'd3,
    PH_CORNER  = 4'd4,
    PH_SETTLE  = 4'd5,
    PH_STOPPED = 4'd6,
    PH_SEEK    = 4'd7,
    PH_EXIT    = 4'd8,
    PH_ARCS    = 4'd9
  } phase_e;

  typedef struct packed {
    logic [TrimW-1:0] right_trim;
    logic [CfgW-1:0]  check_wait;
    logic [CfgW-1:0]  settle_wait;
    logic [CfgW-1:0]  stop_wait;
    logic [CfgW-1:0]  exit_wait;
    logic [CfgW-1:0]  final_wait;
  } cfg_t;

  typedef struct packed {
    logic [DirW-1:0]  dirs;
    logic [DutyW-1:0] left;
    logic [DutyW-1:0] right;
  } move_t;

  typedef struct packed {
    logic            drive;
    move_t           mv;
    logic            hold;
    logic [CfgW-1:0] wait_n;
    phase_e          next_ph;
  } pass_t;

endpackage
`default_nettype wire

[sv/lfms_cfg.sv]
`default_nettype none
module lfms_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lfms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lfms_pkg::CfgW-1:0]   cfg_data_i,
  output lfms_pkg::cfg_t                   cfg_o
);
  import lfms_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RIGHT_TRIM:  cfg_d.right_trim  = cfg_data_i[TrimW-1:0];
        CFG_CHECK_WAIT:  cfg_d.check_wait  = cfg_data_i;
        CFG_SETTLE_WAIT: cfg_d.settle_wait = cfg_data_i;
        CFG_STOP_WAIT:   cfg_d.stop_wait   = cfg_data_i;
        CFG_EXIT_WAIT:   cfg_d.exit_wait   = cfg_data_i;
        CFG_FINAL_WAIT:  cfg_d.final_wait  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.right_trim  <= '0;
      cfg_q.check_wait  <= CheckWaitRst;
      cfg_q.settle_wait <= SettleWaitRst;
      cfg_q.stop_wait   <= StopWaitRst;
      cfg_q.exit_wait   <= ExitWaitRst;
      cfg_q.final_wait  <= FinalWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[sv/lfms_decide.sv]
`default_nettype none
module lfms_decide (
  input  wire lfms_pkg::phase_e           phase_i,
  input  wire logic [lfms_pkg::SensW-1:0] sensors_i,
  input  wire lfms_pkg::cfg_t             cfg_i,
  output lfms_pkg::pass_t                 pass_o
);
  import lfms_pkg::*;

  function automatic move_t mk(input logic [DirW-1:0] d, input logic [DutyW-1:0] l,
                               input logic [DutyW-1:0] r, input logic [TrimW-1:0] t);
    move_t m;
    m.dirs  = d;
    m.left  = l;
    m.right = r + DutyW'(t);
    return m;
  endfunction

  move_t mv_straight, mv_left, mv_right, mv_stop, mv_pivot, mv_final;
  move_t mv_arc_l, mv_arc_r;

  assign mv_straight = mk(DirFwd, DutyCruise, DutyCruise, cfg_i.right_trim);
  assign mv_left     = mk(DirFwd, DutySlow, DutyFast, cfg_i.right_trim);
  assign mv_right    = mk(DirFwd, DutyFast, DutySlow, cfg_i.right_trim);
  assign mv_stop     = mk(DirStop, '0, '0, '0);
  assign mv_pivot    = mk(DirPivot, DutySlow, DutyCrawl, cfg_i.right_trim);
  assign mv_final    = mk(DirOneWhl, DutySlow, '0, '0);
  assign mv_arc_l    = mk(DirFwd, DutyCrawl, DutyArcHi, cfg_i.right_trim);
  assign mv_arc_r    = mk(DirFwd, DutyArcMax, DutyCrawl, '0);

  // The pass falls through the checks in order; a check that starts a wait
  // ends the pass, as does the seek check; otherwise control moves on to the later checks.
  always_comb begin
    phase_e at;
    logic   done;
    pass_o         = '0;
    pass_o.next_ph = PH_PASS;
    done           = 1'b0;
    unique case (phase_i)
      PH_PASS, PH_RCHECK, PH_LTURN, PH_LCHECK, PH_CORNER, PH_SETTLE,
      PH_STOPPED, PH_SEEK, PH_EXIT, PH_ARCS: at = phase_i;
      default: at = PH_PASS;
    endcase

    if (at == PH_PASS) begin
      if (sensors_i == SensNone) begin
        pass_o.drive = 1'b1;
        pass_o.mv    = mv_stop;
      end
      if (sensors_i == SensAll || sensors_i == SensCentre) begin
        pass_o.drive = 1'b1;
        pass_o.mv    = mv_straight;
      end
      if (sensors_i == SensInnerR) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_right;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.check_wait;
        pass_o.next_ph = PH_RCHECK;
        done           = 1'b1;
      end else begin
        at = PH_LTURN;
      end
    end
    if (!done && at == PH_RCHECK) begin
      if (sensors_i == SensNone) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_left;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.settle_wait;
        pass_o.next_ph = PH_LTURN;
        done           = 1'b1;
      end else begin
        at = PH_LTURN;
      end
    end
    if (!done && at == PH_LTURN) begin
      if (sensors_i == SensInnerL) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_left;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.check_wait;
        pass_o.next_ph = PH_LCHECK;
        done           = 1'b1;
      end else begin
        at = PH_CORNER;
      end
    end
    if (!done && at == PH_LCHECK) begin
      if (sensors_i == SensNone) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_right;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.settle_wait;
        pass_o.next_ph = PH_CORNER;
        done           = 1'b1;
      end else begin
        at = PH_CORNER;
      end
    end
    if (!done && at == PH_CORNER) begin
      if (sensors_i == SensCornerA || sensors_i == SensCornerB) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_straight;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.settle_wait;
        pass_o.next_ph = PH_SETTLE;
        done           = 1'b1;
      end else begin
        at = PH_ARCS;
      end
    end
    if (!done && at == PH_SETTLE) begin
      if (sensors_i == SensNone) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_stop;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.stop_wait;
        pass_o.next_ph = PH_STOPPED;
        done           = 1'b1;
      end else begin
        at = PH_ARCS;
      end
    end
    if (!done && at == PH_STOPPED) begin
      pass_o.drive = 1'b1;
      pass_o.mv    = mv_pivot;
      at           = PH_SEEK;
    end
    if (!done && at == PH_SEEK) begin
      pass_o.next_ph = PH_SEEK;
      if (sensors_i == SensInnerL || sensors_i == SensCentre) begin
        pass_o.drive   = 1'b1;
        pass_o.mv      = mv_straight;
        pass_o.hold    = 1'b1;
        pass_o.wait_n  = cfg_i.exit_wait;
        pass_o.next_ph = PH_EXIT;
      end
      done = 1'b1;
    end
    if (!done && at == PH_EXIT) begin
      pass_o.drive   = 1'b1;
      pass_o.mv      = mv_final;
      pass_o.hold    = 1'b1;
      pass_o.wait_n  = cfg_i.final_wait;
      pass_o.next_ph = PH_ARCS;
      done           = 1'b1;
    end
    if (!done) begin
      if (sensors_i == SensOuterL) begin
        pass_o.drive = 1'b1;
        pass_o.mv    = mv_arc_l;
      end
      if (sensors_i == SensOuterR) begin
        pass_o.drive = 1'b1;
        pass_o.mv    = mv_arc_r;
      end
    end
  end

endmodule
`default_nettype wire

[sv/line_follower_motor_sequencer.sv]
// Channel  Dir  Handshake                       Payload
// s_axis   in   s_axis_tvalid_i/s_axis_tready_o  sensors
// m_axis   out  m_axis_tvalid_o/m_axis_tready_i  bridge_dirs, duty_left, duty_right, busy_res
// cfg      in   cfg_we_i (no back-pressure)      register index and value
//
// One item per cycle is sustained while the output is not stalled; the result
// of an item passes through the input register, then the result register.
// The decision pass and the wait countdown both sit between those two registers.
// Reset clears the phase, the countdown and the motor outputs, and loads the
// configuration reset values.
// A stall on the output holds both registers; the input side stalls only
// once both are full.
`default_nettype none
module line_follower_motor_sequencer #(
  parameter int WAIT_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [3:0] sensors
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [3:0] bridge_dirs, [9:4] duty_left,
                                             // [15:10] duty_right, [16] busy_res
  input  wire logic        cfg_we_i,
  input  wire logic [lfms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lfms_pkg::CfgW-1:0]    cfg_data_i
);
  import lfms_pkg::*;

  localparam int WideW = (WAIT_BITS > CfgW) ? WAIT_BITS : CfgW;
  localparam logic [WideW-1:0] WaitMaxW = WideW'((64'd1 << WAIT_BITS) - 64'd1);
  localparam logic [WAIT_BITS-1:0] CntOne = WAIT_BITS'(1);

  cfg_t  cfg;
  pass_t pass;

  logic             in_valid_q, in_valid_d;
  logic [SensW-1:0] sens_q;
  logic             out_valid_q;
  logic [23:0]      out_data_q;

  phase_e               phase_q, phase_d;
  logic [WAIT_BITS-1:0] cnt_q, cnt_d;
  move_t                mv_q, mv_d;

  logic advance, step, s_accept;
  logic [WideW-1:0]     wait_w;
  logic [WAIT_BITS-1:0] wait_sat;

  lfms_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfms_decide u_decide (
    .phase_i   (phase_q),
    .sensors_i (sens_q),
    .cfg_i     (cfg),
    .pass_o    (pass)
  );

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Wait length: saturate to the counter range, and a zero wait counts as one.
  always_comb begin
    wait_w = WideW'(pass.wait_n);
    if (wait_w > WaitMaxW) begin
      wait_w = WaitMaxW;
    end
    wait_sat = wait_w[WAIT_BITS-1:0];
    if (wait_sat == '0) begin
      wait_sat = CntOne;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    mv_d    = mv_q;
    if (cnt_q > CntOne) begin
      cnt_d = cnt_q - CntOne;
    end else begin
      cnt_d   = '0;
      phase_d = pass.next_ph;
      if (pass.drive) begin
        mv_d = pass.mv;
      end
      if (pass.hold) begin
        cnt_d = wait_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_PASS;
      cnt_q       <= '0;
      mv_q        <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        out_valid_q <= step;
      end
      if (step) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        mv_q    <= mv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sens_q <= s_axis_tdata_i[SensW-1:0];
    end
    if (step) begin
      out_data_q <= {7'd0, (phase_d != PH_PASS), mv_d.right, mv_d.left, mv_d.dirs};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_cnt_has_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (phase_q != PH_PASS))
    else $error("countdown running without a pending phase");

  a_hold_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cnt_q > CntOne) |=> (phase_q == $past(phase_q)))
    else $error("phase moved during a timed wait");

  a_hold_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cnt_q > CntOne) |=> (mv_q == $past(mv_q)))
    else $error("motor outputs changed during a timed wait");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with an empty result register");

endmodule
`default_nettype wire
